### rtl/bmc_pkg.sv
// ----------------------------------------------------------------------------
// bmc_pkg - shared types and constants for the button menu controller
// Menu states, command codes, the page navigation table and result layout.
// ----------------------------------------------------------------------------
package bmc_pkg;

    localparam int unsigned CfgWidth     = 8;
    localparam int unsigned InDataWidth  = 8;
    localparam int unsigned OutDataWidth = 24;
    localparam logic [7:0]  HoldLimitRst = 8'd60;
    localparam logic [1:0]  DebugLvlRst  = 2'd3;
    localparam logic [7:0]  HoldCntMax   = 8'd255;
    localparam logic [7:0]  TurnOnLeave  = 8'd255;
    localparam logic [7:0]  TurnOnRestore = 8'd254;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CHECK = 2'd1,
        ST_MENU  = 2'd2
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_SELECT  = 3'd1,
        CMD_CYCLE   = 3'd2,
        CMD_SAVE    = 3'd3,
        CMD_REBUILD = 3'd4
    } t_cmd;

    // settings pages
    localparam logic [2:0] PG_ROOT    = 3'd0;
    localparam logic [2:0] PG_IDLE    = 3'd1;
    localparam logic [2:0] PG_TURN_ON = 3'd2;
    localparam logic [2:0] PG_MODE_ON = 3'd3;
    localparam logic [2:0] PG_REBUILD = 3'd4;
    localparam logic [2:0] PG_DEBUG   = 3'd5;

    // idle behaviour codes
    localparam logic [1:0] IB_SELECT = 2'd0;
    localparam logic [1:0] IB_CYCLE  = 2'd1;

    // one result item, 22 bits, first field highest
    typedef struct packed {
        logic [2:0] menu_page;
        logic [1:0] menu_state;
        logic [1:0] debug_level;
        logic [7:0] turn_on_behaviour;
        logic [1:0] idle_behaviour;
        logic [1:0] command_arg;
        t_cmd       command;
    } t_result;

    // next page after a button on the given page
    function automatic logic [2:0] next_page(input logic [2:0] page, input logic [1:0] btn);
        logic [2:0] nxt;
        nxt = PG_ROOT;
        case (page)
            PG_ROOT: begin
                case (btn)
                    2'd0:    nxt = PG_IDLE;
                    2'd1:    nxt = PG_TURN_ON;
                    2'd2:    nxt = PG_REBUILD;
                    default: nxt = PG_DEBUG;
                endcase
            end
            PG_TURN_ON: begin
                case (btn)
                    2'd2:    nxt = PG_MODE_ON;
                    2'd3:    nxt = PG_TURN_ON;
                    default: nxt = PG_ROOT;
                endcase
            end
            default: nxt = PG_ROOT;
        endcase
        return nxt;
    endfunction

    // lowest pressed mode button, 0 when none
    function automatic logic [1:0] lowest_btn(input logic [3:0] bits);
        logic [1:0] idx;
        idx = 2'd0;
        if (bits[0])      idx = 2'd0;
        else if (bits[1]) idx = 2'd1;
        else if (bits[2]) idx = 2'd2;
        else if (bits[3]) idx = 2'd3;
        return idx;
    endfunction

endpackage

### rtl/button_menu_controller.sv
// ----------------------------------------------------------------------------
// button_menu_controller - setup/mode button menu logic
// Turns debounced button samples into mode commands and settings changes.
// ----------------------------------------------------------------------------
// Output: a sample's result is written into the result buffer by the
//   transaction that accepts it and is then offered on the master side.
// Throughput: one sample per cycle; the two-entry result buffer keeps
//   s_tready high until two results wait unread.
// Reset (synchronous, active low): idle state, latch clear, debug level 3,
//   hold limit 60, result buffer empty.
// ----------------------------------------------------------------------------
module button_menu_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config: hold_limit
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bmc_pkg::CfgWidth-1:0]      i_cfg_data,
    // tdata: [0] setup_pressed, [4:1] mode_buttons, [7:5] zero
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bmc_pkg::InDataWidth-1:0]   s_axis_tdata,
    // tdata: [2:0] command, [4:3] command_arg, [6:5] idle_behaviour_out,
    //   [14:7] turn_on_behaviour_out, [16:15] debug_level_out,
    //   [18:17] menu_state_out, [21:19] menu_page_out, [23:22] zero
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bmc_pkg::OutDataWidth-1:0]  m_axis_tdata
);
    import bmc_pkg::*;

    logic    w_go;
    logic    w_ready;
    t_result w_result;
    t_result w_out;

    // config is always taken; the user must write it only while the block is idle; the block does not check
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_ready;
    // a sample is processed in the cycle it is accepted
    assign w_go          = s_axis_tvalid && w_ready;

    bmc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_go       (w_go),
        .i_setup    (s_axis_tdata[0]),
        .i_buttons  (s_axis_tdata[4:1]),
        .o_result   (w_result)
    );

    // result register stage, two deep; input waits only while both entries are full
    bmc_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_go),
        .i_data      (w_result),
        .o_ready     (w_ready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_data      (w_out)
    );

    assign m_axis_tdata = {2'b00, w_out};

endmodule

### rtl/bmc_core.sv
// ----------------------------------------------------------------------------
// bmc_core - menu state machine and settings registers
// Updates state for one accepted button sample per cycle and forms its result.
// ----------------------------------------------------------------------------
module bmc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_go,
    input  logic                i_setup,
    input  logic [3:0]          i_buttons,
    output bmc_pkg::t_result    o_result
);
    import bmc_pkg::*;

    t_state     r_state,   n_state;
    logic       r_latched, n_latched;
    logic [7:0] r_hold,    n_hold;
    logic [2:0] r_page,    n_page;
    logic [1:0] r_idle,    n_idle;
    logic [7:0] r_turn_on, n_turn_on;
    logic [1:0] r_debug,   n_debug;
    logic [7:0] r_limit;
    t_cmd       n_cmd;
    logic [1:0] n_arg;
    logic       w_valid;
    logic [1:0] w_sel;
    logic [7:0] w_hold_inc;

    assign w_valid    = |i_buttons;
    assign w_sel      = lowest_btn(i_buttons);
    assign w_hold_inc = (r_hold == HoldCntMax) ? r_hold : r_hold + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= HoldLimitRst;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_latched = r_latched;
        n_hold    = r_hold;
        n_page    = r_page;
        n_idle    = r_idle;
        n_turn_on = r_turn_on;
        n_debug   = r_debug;
        n_cmd     = CMD_NONE;
        n_arg     = 2'd0;
        if (r_latched) begin
            if (!i_setup && !w_valid) n_latched = 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_setup) begin
                        n_state = ST_CHECK;
                    end else if (w_valid) begin
                        if (r_idle == IB_SELECT) begin
                            n_cmd = CMD_SELECT;
                            n_arg = w_sel;
                        end else if (r_idle == IB_CYCLE) begin
                            n_cmd = CMD_CYCLE;
                            n_arg = w_sel;
                        end
                        n_latched = 1'b1;
                    end
                end
                ST_CHECK: begin
                    n_hold = w_hold_inc;
                    if (!i_setup) begin
                        // short press toggles select <-> cycle; other codes go to select
                        n_hold    = 8'd0;
                        n_state   = ST_IDLE;
                        n_idle    = (r_idle == IB_SELECT) ? IB_CYCLE : IB_SELECT;
                        n_latched = 1'b1;
                    end else if (w_hold_inc >= r_limit) begin
                        n_latched = 1'b1;
                        n_hold    = 8'd0;
                        if (w_valid) begin
                            n_cmd   = CMD_SAVE;
                            n_arg   = w_sel;
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_MENU;
                        end
                    end
                end
                ST_MENU: begin
                    if (i_setup) begin
                        n_state   = ST_IDLE;
                        n_page    = PG_ROOT;
                        n_latched = 1'b1;
                    end else if (w_valid) begin
                        case (r_page)
                            PG_IDLE:    n_idle = w_sel;
                            PG_TURN_ON: begin
                                if (w_sel == 2'd0)      n_turn_on = TurnOnLeave;
                                else if (w_sel == 2'd1) n_turn_on = TurnOnRestore;
                            end
                            PG_MODE_ON: n_turn_on = {6'd0, w_sel};
                            PG_REBUILD: begin
                                n_cmd = CMD_REBUILD;
                                n_arg = w_sel;
                            end
                            PG_DEBUG:   n_debug = w_sel;
                            default:    ;
                        endcase
                        n_page    = next_page(r_page, w_sel);
                        n_latched = 1'b1;
                    end
                end
                default: n_state = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_latched <= 1'b0;
            r_hold    <= 8'd0;
            r_page    <= PG_ROOT;
            r_idle    <= IB_SELECT;
            r_turn_on <= 8'd0;
            r_debug   <= DebugLvlRst;
        end else if (i_go) begin
            r_state   <= n_state;
            r_latched <= n_latched;
            r_hold    <= n_hold;
            r_page    <= n_page;
            r_idle    <= n_idle;
            r_turn_on <= n_turn_on;
            r_debug   <= n_debug;
        end
    end

    always_comb begin
        o_result.command           = n_cmd;
        o_result.command_arg       = n_arg;
        o_result.idle_behaviour    = n_idle;
        o_result.turn_on_behaviour = n_turn_on;
        o_result.debug_level       = n_debug;
        o_result.menu_state        = n_state;
        o_result.menu_page         = n_page;
    end

    // page only moves inside the menu
    a_page_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_MENU |-> r_page == PG_ROOT)
        else $error("page nonzero outside menu");

    // hold counter only runs during the long press check
    a_hold_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_CHECK |-> r_hold == 8'd0)
        else $error("hold count not cleared");

    // any command arms the action latch
    a_cmd_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && n_cmd != CMD_NONE |=> r_latched)
        else $error("command without latch");

    // no command while latched
    a_latched_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched |-> n_cmd == CMD_NONE)
        else $error("command while latched");

endmodule

### rtl/bmc_obuf.sv
// ----------------------------------------------------------------------------
// bmc_obuf - two-entry result buffer
// Holds two finished results; input stalls only while both wait unread.
// ----------------------------------------------------------------------------
module bmc_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bmc_pkg::t_result    i_data,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_pop_ready,
    output bmc_pkg::t_result    o_data
);
    import bmc_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_pop_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("buffer count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wr_ptr == r_rd_ptr)
        else $error("buffer pointers disagree with count");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != 2'd2)
        else $error("push into full buffer");

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the button menu controller
// Drives debounced button samples through the stream input and checks every
// result against a typed expectation or a cycle-free model of the menu
// logic. A short table of directed samples comes first, then random button
// sequences under several hold limits, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import bmc_pkg::*;

    localparam int unsigned CycleLimit   = 500000;
    localparam int unsigned RxHoldCycles = 80;
    localparam int unsigned PhaseItems   = 220;
    localparam int unsigned NumPhases    = 6;
    // idle behaviour code that maps a mode button to no action
    localparam logic [1:0]  IB_NONE      = 2'd3;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CfgWidth-1:0]     i_cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [InDataWidth-1:0]  s_axis_tdata;   // [0] setup, [4:1] mode buttons
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OutDataWidth-1:0] m_axis_tdata;   // t_result in [21:0], zero above

    button_menu_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Menu model state (mirrors the block's registers)
    // ------------------------------------------------------------------------
    t_state      cur_state;
    logic        latch_on;
    logic [7:0]  hold_cnt;
    logic [2:0]  cur_page;
    logic [1:0]  idle_beh;
    logic [7:0]  turn_on;
    logic [1:0]  debug_lvl;
    logic [7:0]  hold_lim;

    // next page per (page, lowest button)
    logic [2:0] page_next [6][4] = '{
        '{PG_IDLE, PG_TURN_ON, PG_REBUILD, PG_DEBUG},
        '{4{PG_ROOT}},
        '{PG_ROOT, PG_ROOT, PG_MODE_ON, PG_TURN_ON},
        '{4{PG_ROOT}},
        '{4{PG_ROOT}},
        '{4{PG_ROOT}}
    };

    t_result pending_outputs [$];   // results owed by the block, oldest first

    int unsigned errors    = 0;
    int unsigned n_items   = 0;
    int unsigned n_checked = 0;
    int unsigned n_cfg     = 0;
    int unsigned cycles    = 0;
    int unsigned cmd_count [5] = '{5{0}};

    bit quiet       = 1'b0;    // no idling on either side
    bit rx_hold_req = 1'b0;    // ask the receiver for one long hold-off
    bit rx_holding  = 1'b0;

    // Apply one button sample to the model; returns the result it should produce.
    task automatic menu_predict(input logic setup, input logic [3:0] btn,
                                output t_result r);
        logic       any;
        logic [1:0] s;
        t_cmd       cmd;
        logic [1:0] arg;
        any = |btn;
        s   = btn[0] ? 2'd0 : btn[1] ? 2'd1 : btn[2] ? 2'd2 : 2'd3;
        cmd = CMD_NONE;
        arg = 2'd0;
        if (!latch_on) begin
            case (cur_state)
                ST_IDLE: begin
                    if (setup) begin
                        cur_state = ST_CHECK;
                    end else if (any) begin
                        if (idle_beh == IB_SELECT) begin
                            cmd = CMD_SELECT;
                            arg = s;
                        end else if (idle_beh == IB_CYCLE) begin
                            cmd = CMD_CYCLE;
                            arg = s;
                        end
                        latch_on = 1'b1;
                    end
                end
                ST_CHECK: begin
                    if (hold_cnt != HoldCntMax) hold_cnt = hold_cnt + 8'd1;
                    if (!setup) begin
                        // short press flips select <-> cycle, other codes go to select
                        hold_cnt  = 8'd0;
                        cur_state = ST_IDLE;
                        idle_beh  = (idle_beh == IB_SELECT) ? IB_CYCLE : IB_SELECT;
                        latch_on  = 1'b1;
                    end else if (hold_cnt >= hold_lim) begin
                        latch_on = 1'b1;
                        hold_cnt = 8'd0;
                        if (any) begin
                            cmd       = CMD_SAVE;
                            arg       = s;
                            cur_state = ST_IDLE;
                        end else begin
                            cur_state = ST_MENU;
                        end
                    end
                end
                ST_MENU: begin
                    if (setup) begin
                        cur_state = ST_IDLE;
                        cur_page  = PG_ROOT;
                        latch_on  = 1'b1;
                    end else if (any) begin
                        case (cur_page)
                            PG_IDLE:    idle_beh = s;
                            PG_TURN_ON: begin
                                if (s == 2'd0)      turn_on = TurnOnLeave;
                                else if (s == 2'd1) turn_on = TurnOnRestore;
                            end
                            PG_MODE_ON: turn_on = {6'd0, s};
                            PG_REBUILD: begin
                                cmd = CMD_REBUILD;
                                arg = s;
                            end
                            PG_DEBUG:   debug_lvl = s;
                            default: ;
                        endcase
                        cur_page = (cur_page < 3'd6) ? page_next[cur_page][s] : PG_ROOT;
                        latch_on = 1'b1;
                    end
                end
                default: cur_state = ST_IDLE;
            endcase
        end else if (!setup && !any) begin
            latch_on = 1'b0;
        end
        r.command           = cmd;
        r.command_arg       = arg;
        r.idle_behaviour    = idle_beh;
        r.turn_on_behaviour = turn_on;
        r.debug_level       = debug_lvl;
        r.menu_state        = cur_state;
        r.menu_page         = cur_page;
    endtask

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    typedef enum {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        setup;
        logic [3:0]  btn;
        int unsigned reps;     // sample repeated this many times
        int unsigned rels;     // all-released samples appended
        bit          typed;    // last repeat checked against want
        t_result     want;
        logic [7:0]  cfg_val;
    } t_dir_row;

    t_dir_row dir_tab [$];

    function automatic t_result outcome(t_cmd c, logic [1:0] arg, logic [1:0] ib,
                                        logic [7:0] tob, logic [1:0] dbg,
                                        t_state st, logic [2:0] pg);
        t_result r;
        r.command           = c;
        r.command_arg       = arg;
        r.idle_behaviour    = ib;
        r.turn_on_behaviour = tob;
        r.debug_level       = dbg;
        r.menu_state        = st;
        r.menu_page         = pg;
        return r;
    endfunction

    function automatic t_dir_row step_row(logic s, logic [3:0] b, int unsigned reps,
                                          int unsigned rels);
        t_dir_row row;
        row.kind    = ROW_ITEM;
        row.setup   = s;
        row.btn     = b;
        row.reps    = reps;
        row.rels    = rels;
        row.typed   = 1'b0;
        row.want    = '0;
        row.cfg_val = 8'd0;
        return row;
    endfunction

    function automatic t_dir_row checked_row(logic s, logic [3:0] b, int unsigned reps,
                                             int unsigned rels, t_result want);
        t_dir_row row;
        row       = step_row(s, b, reps, rels);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(logic [7:0] v);
        t_dir_row row;
        row         = step_row(1'b0, 4'd0, 0, 0);
        row.kind    = ROW_CFG;
        row.cfg_val = v;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // One input transaction. The expectation is queued up front; the block
    // only answers after the handshake, so ordering is preserved.
    task automatic send_item(input logic setup, input logic [3:0] btn,
                             input bit typed, input t_result typed_res);
        t_result pred;
        menu_predict(setup, btn, pred);
        pending_outputs.push_back(typed ? typed_res : pred);
        if (!quiet && !rx_holding && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'd0, btn, setup};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_items++;
    endtask

    task automatic press(input logic setup, input logic [3:0] btn, input int unsigned reps);
        repeat (reps) send_item(setup, btn, 1'b0, '0);
    endtask

    // hold_limit write, only with nothing in flight
    task automatic write_hold_limit(input logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        hold_lim = v;
        n_cfg++;
    endtask

    // Random button sequences. Mostly well-formed gestures (taps, short and
    // long setup holds, menu walks, saves) so the deeper states get reached;
    // the rest is raw noise.
    task automatic run_random(input int unsigned budget);
        int unsigned start;
        int unsigned kind;
        int unsigned n;
        start = n_items;
        while (n_items - start < budget) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    press(1'b0, 4'($urandom_range(1, 15)), $urandom_range(1, 3));
                    press(1'b0, 4'd0, $urandom_range(1, 2));
                end
                3: begin
                    // released before the limit: short press
                    press(1'b1, 4'($urandom_range(0, 15)),
                          $urandom_range(1, int'(hold_lim)));
                    press(1'b0, 4'd0, $urandom_range(1, 2));
                end
                4, 5, 6: begin
                    // long hold into the menu, walk a few pages, maybe leave
                    press(1'b1, 4'd0, int'(hold_lim) + 1 + $urandom_range(0, 2));
                    press(1'b0, 4'd0, 1);
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        press(1'b0, 4'($urandom_range(1, 15)), $urandom_range(1, 2));
                        press(1'b0, 4'd0, 1);
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        press(1'b1, 4'($urandom_range(0, 15)), $urandom_range(1, 2));
                        press(1'b0, 4'd0, 1);
                    end
                end
                7: begin
                    // long hold with a mode button: save
                    press(1'b1, 4'($urandom_range(1, 15)),
                          int'(hold_lim) + 1 + $urandom_range(0, 1));
                    press(1'b0, 4'd0, 1);
                end
                default: begin
                    n = $urandom_range(1, 6);
                    repeat (n) press(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 1);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            if (rx_hold_req) begin
                // long stall so the result buffer fills and the input backs up
                rx_hold_req = 1'b0;
                rx_holding  = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (RxHoldCycles) @(posedge i_clk);
                rx_holding  = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    t_result got_res;
    t_result want_res;

    task automatic cmp(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res = t_result'(m_axis_tdata[21:0]);
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                want_res = pending_outputs.pop_front();
                cmp("command",           want_res.command,           got_res.command);
                cmp("command_arg",       want_res.command_arg,       got_res.command_arg);
                cmp("idle_behaviour",    want_res.idle_behaviour,    got_res.idle_behaviour);
                cmp("turn_on_behaviour", want_res.turn_on_behaviour,
                    got_res.turn_on_behaviour);
                cmp("debug_level",       want_res.debug_level,       got_res.debug_level);
                cmp("menu_state",        want_res.menu_state,        got_res.menu_state);
                cmp("menu_page",         want_res.menu_page,         got_res.menu_page);
                cmp("tdata pad",         0,                          m_axis_tdata[23:22]);
                n_checked++;
                if (int'(got_res.command) < 5) cmd_count[int'(got_res.command)]++;
            end
        end
    end

    // watchdog
    initial begin
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, pending_outputs.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    logic [7:0] phase_lim [NumPhases] = '{8'd1, 8'd4, 8'd255, 8'd2, 8'd60, 8'd1};

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= 8'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;

        cur_state = ST_IDLE;
        latch_on  = 1'b0;
        hold_cnt  = 8'd0;
        cur_page  = PG_ROOT;
        idle_beh  = IB_SELECT;
        turn_on   = 8'd0;
        debug_lvl = DebugLvlRst;
        hold_lim  = HoldLimitRst;

        // Directed walk. Runs on the reset hold limit first, then the two
        // extremes. Typed rows pin the state right after reset, the lowest-
        // button priority, short and long presses, every menu page action,
        // menu exit, the no-action idle behaviour, save, and a hold that
        // runs the counter up to its top value.
        dir_tab.push_back(checked_row(1'b0, 4'b0000, 1, 0, outcome(CMD_NONE, 2'd0,
            IB_SELECT, 8'd0, DebugLvlRst, ST_IDLE, PG_ROOT)));
        dir_tab.push_back(checked_row(1'b0, 4'b1000, 1, 1, outcome(CMD_SELECT, 2'd3,
            IB_SELECT, 8'd0, DebugLvlRst, ST_IDLE, PG_ROOT)));
        dir_tab.push_back(checked_row(1'b0, 4'b0110, 1, 1, outcome(CMD_SELECT, 2'd1,
            IB_SELECT, 8'd0, DebugLvlRst, ST_IDLE, PG_ROOT)));
        dir_tab.push_back(checked_row(1'b1, 4'b0000, 3, 2, outcome(CMD_NONE, 2'd0,
            IB_SELECT, 8'd0, DebugLvlRst, ST_CHECK, PG_ROOT)));
        dir_tab.push_back(checked_row(1'b0, 4'b0100, 1, 1, outcome(CMD_CYCLE, 2'd2,
            IB_CYCLE, 8'd0, DebugLvlRst, ST_IDLE, PG_ROOT)));
        // entry tick plus 60 counted ticks reaches the reset limit
        dir_tab.push_back(checked_row(1'b1, 4'b0000, 61, 1, outcome(CMD_NONE, 2'd0,
            IB_CYCLE, 8'd0, DebugLvlRst, ST_MENU, PG_ROOT)));
        dir_tab.push_back(checked_row(1'b0, 4'b1111, 1, 1, outcome(CMD_NONE, 2'd0,
            IB_CYCLE, 8'd0, DebugLvlRst, ST_MENU, PG_IDLE)));
        dir_tab.push_back(checked_row(1'b0, 4'b1000, 1, 1, outcome(CMD_NONE, 2'd0,
            IB_NONE, 8'd0, DebugLvlRst, ST_MENU, PG_ROOT)));
        dir_tab.push_back(step_row(1'b0, 4'b0010, 1, 1));
        dir_tab.push_back(checked_row(1'b0, 4'b0010, 1, 1, outcome(CMD_NONE, 2'd0,
            IB_NONE, TurnOnRestore, DebugLvlRst, ST_MENU, PG_ROOT)));
        dir_tab.push_back(step_row(1'b0, 4'b0010, 1, 1));
        dir_tab.push_back(step_row(1'b0, 4'b1000, 1, 1));      // turn-on page, no-op button
        dir_tab.push_back(checked_row(1'b0, 4'b0001, 1, 1, outcome(CMD_NONE, 2'd0,
            IB_NONE, TurnOnLeave, DebugLvlRst, ST_MENU, PG_ROOT)));
        dir_tab.push_back(step_row(1'b0, 4'b0010, 1, 1));
        dir_tab.push_back(step_row(1'b0, 4'b0100, 1, 1));      // on to the mode page
        dir_tab.push_back(checked_row(1'b0, 4'b1000, 1, 1, outcome(CMD_NONE, 2'd0,
            IB_NONE, 8'd3, DebugLvlRst, ST_MENU, PG_ROOT)));
        dir_tab.push_back(step_row(1'b0, 4'b0100, 1, 1));
        dir_tab.push_back(checked_row(1'b0, 4'b1100, 1, 1, outcome(CMD_REBUILD, 2'd2,
            IB_NONE, 8'd3, DebugLvlRst, ST_MENU, PG_ROOT)));
        dir_tab.push_back(step_row(1'b0, 4'b1000, 1, 1));
        dir_tab.push_back(checked_row(1'b0, 4'b0001, 1, 1, outcome(CMD_NONE, 2'd0,
            IB_NONE, 8'd3, 2'd0, ST_MENU, PG_ROOT)));
        dir_tab.push_back(checked_row(1'b1, 4'b0101, 1, 1, outcome(CMD_NONE, 2'd0,
            IB_NONE, 8'd3, 2'd0, ST_IDLE, PG_ROOT)));
        dir_tab.push_back(checked_row(1'b0, 4'b0001, 1, 1, outcome(CMD_NONE, 2'd0,
            IB_NONE, 8'd3, 2'd0, ST_IDLE, PG_ROOT)));
        dir_tab.push_back(step_row(1'b1, 4'b0000, 1, 2));      // short press from no-action
        dir_tab.push_back(cfg_row(8'd1));
        dir_tab.push_back(checked_row(1'b1, 4'b1000, 2, 1, outcome(CMD_SAVE, 2'd3,
            IB_SELECT, 8'd3, 2'd0, ST_IDLE, PG_ROOT)));
        dir_tab.push_back(cfg_row(8'd255));
        dir_tab.push_back(checked_row(1'b1, 4'b0000, 256, 1, outcome(CMD_NONE, 2'd0,
            IB_SELECT, 8'd3, 2'd0, ST_MENU, PG_ROOT)));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                write_hold_limit(dir_tab[i].cfg_val);
            end else begin
                if (dir_tab[i].reps > 1)
                    press(dir_tab[i].setup, dir_tab[i].btn, dir_tab[i].reps - 1);
                send_item(dir_tab[i].setup, dir_tab[i].btn, dir_tab[i].typed,
                          dir_tab[i].want);
                press(1'b0, 4'd0, dir_tab[i].rels);
            end
        end

        // Random phases, one hold limit each; the last runs without idling.
        for (int p = 0; p < NumPhases; p++) begin
            write_hold_limit(phase_lim[p]);
            quiet = (p == NumPhases - 1);
            if (p == 0) rx_hold_req = 1'b1;
            run_random(PhaseItems);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Run: %0d button samples, %0d results checked, %0d hold limit writes",
                 n_items, n_checked, n_cfg);
        $display("Commands seen: select %0d, cycle %0d, save %0d, rebuild %0d",
                 cmd_count[CMD_SELECT], cmd_count[CMD_CYCLE], cmd_count[CMD_SAVE],
                 cmd_count[CMD_REBUILD]);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
